@@ rtl/irr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// irr_pkg: shared types for the interval room reservation block
// Request and result payloads, plus the command and status groups that
// connect the controller to the datapath.
// ============================================================================
package irr_pkg;

  localparam int TIME_W     = 16;
  localparam int ROOM_IDX_W = 2;
  localparam int CFG_W      = 3;

  localparam logic [CFG_W-1:0] ROOMS_IN_USE_RESET = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } request_t;

  typedef struct packed {
    logic                  granted;
    logic [ROOM_IDX_W-1:0] room_index;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and start at room zero
    logic room_next;  // move on to the next room
    logic issue;      // read the next stored interval of the room
    logic grant;      // store the request in the room and record a grant
    logic deny;       // record a refusal
    logic out_load;   // move the recorded result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic room_in_limit;  // current room is one of the rooms searched
    logic room_full;      // current room has no free entry
    logic scan_more;      // stored intervals of this room remain to be read
    logic pending;        // read data waits to be compared
    logic hit;            // the read interval overlaps the request
  } ctrl_status_t;

endpackage

@@ rtl/irr_dpath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// irr_dpath: interval table, fill counters and overlap compare
// Holds the stored intervals in one memory, a fill count per room and the
// result register. Intervals are never removed, so a room's valid entries
// always form a prefix and the fill count tells which are valid.
// ============================================================================
module irr_dpath #(
  parameter int ROOMS          = 4,
  parameter int SLOTS_PER_ROOM = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [irr_pkg::CFG_W-1:0]   cfg_wdata,
  input  irr_pkg::request_t           request,
  input  irr_pkg::ctrl_cmd_t          cmd,
  output irr_pkg::ctrl_status_t       status,
  output irr_pkg::result_t            result
);

  localparam int TOTAL   = ROOMS * SLOTS_PER_ROOM;
  localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int ROOM_CW = $clog2(ROOMS + 1);
  localparam int ROOM_IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int FILL_W  = $clog2(SLOTS_PER_ROOM + 1);
  localparam int CMP_W   = (ROOM_CW > irr_pkg::CFG_W) ? ROOM_CW : irr_pkg::CFG_W;

  logic [irr_pkg::CFG_W-1:0] rooms_in_use;
  irr_pkg::request_t         req_q;
  logic [ROOM_CW-1:0]        room_cnt;
  logic [ADDR_W-1:0]         base;
  logic [FILL_W-1:0]         slot_cnt;
  logic                      pending;
  logic [FILL_W-1:0]         fill [ROOMS];
  irr_pkg::request_t         mem [TOTAL];
  irr_pkg::request_t         rd_data;
  irr_pkg::result_t          res_q;

  logic [ROOM_IW-1:0]        room_idx;
  logic [FILL_W-1:0]         fill_cur;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ADDR_W-1:0]         wr_addr;

  assign room_idx = room_cnt[ROOM_IW-1:0];
  assign fill_cur = fill[room_idx];
  assign rd_addr  = base + ADDR_W'(slot_cnt);
  assign wr_addr  = base + ADDR_W'(fill_cur);

  always_comb begin
    status.room_in_limit = (CMP_W'(room_cnt) < CMP_W'(rooms_in_use)) &&
                           (room_cnt < ROOM_CW'(ROOMS));
    status.room_full     = (fill_cur == FILL_W'(SLOTS_PER_ROOM));
    status.scan_more     = (slot_cnt < fill_cur);
    status.pending       = pending;
    status.hit           = pending &&
                           (rd_data.start_time < req_q.end_time) &&
                           (req_q.start_time < rd_data.end_time);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= irr_pkg::ROOMS_IN_USE_RESET;
    end else if (cfg_we) begin
      rooms_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      for (int r = 0; r < ROOMS; r++) begin
        fill[r] <= '0;
      end
    end else begin
      if (cmd.load || cmd.room_next) begin
        pending <= 1'b0;
      end else begin
        pending <= cmd.issue;
      end
      if (cmd.grant) begin
        fill[room_idx] <= fill_cur + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= request;
      room_cnt <= '0;
      base     <= '0;
      slot_cnt <= '0;
    end else if (cmd.room_next) begin
      room_cnt <= room_cnt + ROOM_CW'(1);
      base     <= base + ADDR_W'(SLOTS_PER_ROOM);
      slot_cnt <= '0;
    end else if (cmd.issue) begin
      slot_cnt <= slot_cnt + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.grant) begin
      mem[wr_addr] <= req_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      res_q.granted    <= 1'b1;
      res_q.room_index <= irr_pkg::ROOM_IDX_W'(room_cnt);
    end else if (cmd.deny) begin
      res_q.granted    <= 1'b0;
      res_q.room_index <= '0;
    end
    if (cmd.out_load) begin
      result <= res_q;
    end
  end

endmodule

@@ rtl/irr_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// irr_ctrl: request sequencer
// Walks the rooms one at a time, streams each room's stored intervals
// through the compare and hands the outcome to the output register.
// ============================================================================
module irr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  request_valid,
  output logic                  request_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  output irr_pkg::ctrl_cmd_t    cmd,
  input  irr_pkg::ctrl_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROOM = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign request_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (request_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ROOM;
        end
      end
      S_ROOM: begin
        if (!status.room_in_limit) begin
          cmd.deny   = 1'b1;
          state_next = S_DONE;
        end else if (status.room_full) begin
          cmd.room_next = 1'b1;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.room_next = 1'b1;
          state_next    = S_ROOM;
        end else if (!status.scan_more && !status.pending) begin
          cmd.grant  = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.issue = status.scan_more;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/interval_room_reservation.sv @@
`timescale 1ns / 1ps
// ============================================================================
// interval_room_reservation: first-fit meeting room reservation
// Grants a half-open time interval to the lowest room where it fits.
// ============================================================================
// Each request asks for the interval [start_time, end_time). Rooms are tried
// from room zero up to the number of rooms in use (the rooms_in_use register,
// written through cfg_wdata, reset value 4, capped at ROOMS; zero denies every
// request). A room takes
// the request when it has a free entry and none of its stored intervals
// overlaps it, where a stored (s, e) overlaps when s < end_time and
// start_time < e. The request is stored in that room and the result reports
// granted with the room number; otherwise granted and room_index are zero.
// An empty or inverted interval goes through the same compare and, when
// granted, is stored like any other. A request holds the block while it is
// taken, while its rooms are searched and while its result is loaded: full
// rooms are skipped, each scanned room has its stored intervals read in
// turn, and the search ends at the first room that takes the request or at
// the end of the searched rooms. Reading stops at the first overlap. Loading
// the result also waits while the previous result still sits in the output
// register. Stored intervals are read through the single read port of the
// interval memory, which delivers one stored interval per cycle.
// One request is worked on at a time; a finished result sits in the output
// register, so a new request is taken while the previous result waits.
// After reset the table is empty and no clearing pass is needed; the
// register may only be written while no request is in flight.
// ============================================================================
module interval_room_reservation #(
  parameter int ROOMS          = 4,
  parameter int SLOTS_PER_ROOM = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [irr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      request_valid,
  output logic                      request_ready,
  input  irr_pkg::request_t         request,
  output logic                      result_valid,
  input  logic                      result_ready,
  output irr_pkg::result_t          result
);

  irr_pkg::ctrl_cmd_t    cmd;
  irr_pkg::ctrl_status_t status;

  // The controller sequences rooms and entries; it never sees payload data.
  irr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .cmd           (cmd),
    .status        (status)
  );

  // The datapath owns the interval memory, the per-room fill counts, the
  // room-count register and the output payload register.
  irr_dpath #(
    .ROOMS          (ROOMS),
    .SLOTS_PER_ROOM (SLOTS_PER_ROOM)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

@@ rtl/irr_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// irr_checker: port-level checks for interval_room_reservation
// Watches the top-level ports and flags handshake or result slips.
// ============================================================================
module irr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_we,
  input logic [irr_pkg::CFG_W-1:0] cfg_wdata,
  input logic                      request_valid,
  input logic                      request_ready,
  input irr_pkg::request_t         request,
  input logic                      result_valid,
  input logic                      result_ready,
  input irr_pkg::result_t          result
);

  // A stalled result stays offered with the same payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // Requests are worked on one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !rst && request_valid && request_ready |=> !request_ready)
    else $error("request taken while another is in flight");

  // A refused request reports room zero.
  a_deny_room_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.granted |-> result.room_index == '0)
    else $error("denied result carries a room number");

  // A result only appears after a request has been taken, so the block was
  // busy in the cycle before.
  a_result_after_request: assert property (@(posedge clk) disable iff (rst)
    !rst && $rose(result_valid) |-> !$past(request_ready))
    else $error("result appeared with no request in flight");

endmodule

bind interval_room_reservation irr_checker u_irr_checker (.*);
